FILE: design/tcc_pkg.sv
package tcc_pkg;

  // field widths
  localparam int SAMPLE_W  = 12;
  localparam int POINT_X_W = 8;
  localparam int POINT_Y_W = 9;
  localparam int COEF_W    = 32;
  localparam int CFG_IDX_W = 3;

  // default panel size
  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 320;

  // Q15.16 affine arithmetic
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = COEF_W + SAMPLE_W + 1;
  localparam int SUM_W     = PROD_W + 1;
  localparam int WHOLE_W   = SUM_W - 1 - FRAC_BITS;

  // fallback count window
  localparam int COUNT_LOW  = 300;
  localparam int COUNT_HIGH = 3800;
  localparam int COUNT_SPAN = COUNT_HIGH - COUNT_LOW;

  // fallback product (count - low) * (size - 1), size up to 4096
  localparam int SIZE_W  = 12;
  localparam int SCALE_W = SAMPLE_W + SIZE_W;

  // divide by the span as multiply by reciprocal, exact for SCALE_W-bit operands
  localparam int          DIV_SHIFT = SCALE_W + SIZE_W;
  localparam int          DIV_MUL_W = 25;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL =
    DIV_MUL_W'(((64'd1 << DIV_SHIFT) + 64'(COUNT_SPAN) - 64'd1) / 64'(COUNT_SPAN));
  localparam int QUO_W = SIZE_W + 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIBRATED = 3'd0,
    CFG_COEF_XX    = 3'd1,
    CFG_COEF_XY    = 3'd2,
    CFG_COEF_XOFF  = 3'd3,
    CFG_COEF_YX    = 3'd4,
    CFG_COEF_YY    = 3'd5,
    CFG_COEF_YOFF  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
  } sample_t;

  typedef struct packed {
    logic [POINT_X_W-1:0] point_x;
    logic [POINT_Y_W-1:0] point_y;
  } point_t;

endpackage

FILE: design/touch_coordinate_calibration_top.sv
// channel   | direction | valid        | stall        | payload
// sample    | in        | sample_valid | sample_stall | sample (sample_t)
// point     | out       | point_valid  | point_stall  | point  (point_t)
// cfg       | in        | cfg_write    | none         | cfg_index, cfg_data
//
// one sample per cycle while no point is held under point_stall; a sample passes the
// input register, multiplier stage, sum and reciprocal stage and output register
// rst is synchronous and clears the valid pipeline and the configuration registers
// the whole pipeline holds while a point waits under point_stall; sample_stall
// is raised only then
module touch_coordinate_calibration_top
  import tcc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 point_valid,
  input  logic                 point_stall,
  output point_t               point,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  logic                     calibrated;
  logic signed [COEF_W-1:0] coef_xx, coef_xy, coef_xoff;
  logic signed [COEF_W-1:0] coef_yx, coef_yy, coef_yoff;
  logic                     en;
  logic                     v1, v2, v3;
  sample_t                  sample_r;
  logic [POINT_X_W-1:0]     px;
  logic [POINT_Y_W-1:0]     py;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrated <= 1'b0;
      coef_xx    <= '0;
      coef_xy    <= '0;
      coef_xoff  <= '0;
      coef_yx    <= '0;
      coef_yy    <= '0;
      coef_yoff  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CALIBRATED: calibrated <= cfg_data[0];
        CFG_COEF_XX:    coef_xx    <= cfg_data;
        CFG_COEF_XY:    coef_xy    <= cfg_data;
        CFG_COEF_XOFF:  coef_xoff  <= cfg_data;
        CFG_COEF_YX:    coef_yx    <= cfg_data;
        CFG_COEF_YY:    coef_yy    <= cfg_data;
        CFG_COEF_YOFF:  coef_yoff  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished point is held
  assign en           = !(point_valid && point_stall);
  assign sample_stall = !en;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      point_valid <= 1'b0;
    end else if (en) begin
      v1          <= sample_valid;
      v2          <= v1;
      v3          <= v2;
      point_valid <= v3;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      sample_r <= sample;
    end
  end

  tcc_axis #(
    .SIZE  (SCREEN_WIDTH),
    .OUT_W (POINT_X_W)
  ) u_axis_x (
    .clk        (clk),
    .en         (en),
    .calibrated (calibrated),
    .coef_a     (coef_xx),
    .coef_b     (coef_xy),
    .coef_off   (coef_xoff),
    .rx         (sample_r.sample_x),
    .ry         (sample_r.sample_y),
    .raw        (sample_r.sample_x),
    .point      (px)
  );

  tcc_axis #(
    .SIZE  (SCREEN_HEIGHT),
    .OUT_W (POINT_Y_W)
  ) u_axis_y (
    .clk        (clk),
    .en         (en),
    .calibrated (calibrated),
    .coef_a     (coef_yx),
    .coef_b     (coef_yy),
    .coef_off   (coef_yoff),
    .rx         (sample_r.sample_x),
    .ry         (sample_r.sample_y),
    .raw        (sample_r.sample_y),
    .point      (py)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      point.point_x <= px;
      point.point_y <= py;
    end
  end

endmodule

FILE: design/tcc_axis.sv
module tcc_axis
  import tcc_pkg::*;
#(
  parameter int SIZE  = SCREEN_WIDTH_DEF,
  parameter int OUT_W = POINT_X_W
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     calibrated,
  input  logic signed [COEF_W-1:0] coef_a,
  input  logic signed [COEF_W-1:0] coef_b,
  input  logic signed [COEF_W-1:0] coef_off,
  input  logic [SAMPLE_W-1:0]      rx,
  input  logic [SAMPLE_W-1:0]      ry,
  input  logic [SAMPLE_W-1:0]      raw,
  output logic [OUT_W-1:0]         point
);

  localparam logic [SIZE_W-1:0]  SIZE_M1    = SIZE_W'(SIZE - 1);
  localparam logic [WHOLE_W-1:0] SIZE_WHOLE = WHOLE_W'(SIZE);
  localparam logic [QUO_W-1:0]   SIZE_QUO   = QUO_W'(SIZE);

  logic signed [PROD_W-1:0]   prod_a;
  logic signed [PROD_W-1:0]   prod_b;
  logic [SCALE_W-1:0]         scaled;
  logic                       below;
  logic signed [SUM_W-1:0]    sum;
  logic [QUO_W-1:0]           quo;
  logic                       below_q;
  logic [SAMPLE_W:0]          raw_off;
  logic [DIV_SHIFT+QUO_W-1:0] quo_full;
  logic [WHOLE_W-1:0]         whole;
  logic [SIZE_W-1:0]          clamped;

  // window offset of the raw count, sign in the top bit
  assign raw_off = {1'b0, raw} - (SAMPLE_W + 1)'(COUNT_LOW);

  // products stage
  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= coef_a * $signed({1'b0, rx});
      prod_b <= coef_b * $signed({1'b0, ry});
      scaled <= raw_off[SAMPLE_W-1:0] * SIZE_M1;
      below  <= raw_off[SAMPLE_W];
    end
  end

  // reciprocal multiply for the fallback quotient
  assign quo_full = (DIV_SHIFT + QUO_W)'(scaled * DIV_MUL);

  // sum and quotient stage
  always_ff @(posedge clk) begin
    if (en) begin
      sum     <= {prod_a[PROD_W-1], prod_a} + {prod_b[PROD_W-1], prod_b}
                 + {{(SUM_W - COEF_W){coef_off[COEF_W-1]}}, coef_off};
      quo     <= quo_full[DIV_SHIFT +: QUO_W];
      below_q <= below;
    end
  end

  assign whole = sum[SUM_W-2:FRAC_BITS];

  // floor, then clamp to the screen
  always_comb begin
    if (calibrated) begin
      if (sum[SUM_W-1]) begin
        clamped = '0;
      end else if (whole >= SIZE_WHOLE) begin
        clamped = SIZE_M1;
      end else begin
        clamped = whole[SIZE_W-1:0];
      end
    end else begin
      if (below_q) begin
        clamped = '0;
      end else if (quo >= SIZE_QUO) begin
        clamped = SIZE_M1;
      end else begin
        clamped = quo[SIZE_W-1:0];
      end
    end
  end

  assign point = clamped[OUT_W-1:0];

endmodule

FILE: verif/tcc_point_checker.sv
module tcc_point_checker
  import tcc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  input  logic                 sample_stall,
  input  sample_t              sample,
  input  logic                 point_valid,
  input  logic                 point_stall,
  input  point_t               point,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  output int                   mismatch_count,
  output int                   pending_points
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the calibration registers
  bit calibrated_q;
  int gain_xx, gain_xy, bias_x;
  int gain_yx, gain_yy, bias_y;

  // screen points still owed by the block, oldest first
  point_t expected_points[$];

  function automatic longint clamp_axis(longint v, longint size);
    if (v < 0) return 0;
    if (v >= size) return size - 1;
    return v;
  endfunction

  // exact Q15.16 sum, floored, then clamped to the panel
  function automatic longint affine_axis(int a, int b, int off, longint rx, longint ry,
                                         longint size);
    longint sum;
    sum = longint'(a) * rx + longint'(b) * ry + longint'(off);
    if (sum < 0) return 0;
    return clamp_axis(sum >>> FRAC_BITS, size);
  endfunction

  // fallback window map, division truncates toward zero
  function automatic longint linear_axis(longint raw, longint size);
    return clamp_axis((raw - COUNT_LOW) * (size - 1) / COUNT_SPAN, size);
  endfunction

  function automatic point_t predict_point(sample_t s);
    longint rx;
    longint ry;
    longint px;
    longint py;
    point_t p;
    rx = longint'(s.sample_x);
    ry = longint'(s.sample_y);
    if (calibrated_q) begin
      px = affine_axis(gain_xx, gain_xy, bias_x, rx, ry, SCREEN_WIDTH);
      py = affine_axis(gain_yx, gain_yy, bias_y, rx, ry, SCREEN_HEIGHT);
    end else begin
      px = linear_axis(rx, SCREEN_WIDTH);
      py = linear_axis(ry, SCREEN_HEIGHT);
    end
    p.point_x = POINT_X_W'(px);
    p.point_y = POINT_Y_W'(py);
    return p;
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      calibrated_q = 1'b0;
      gain_xx = 0;
      gain_xy = 0;
      bias_x  = 0;
      gain_yx = 0;
      gain_yy = 0;
      bias_y  = 0;
      expected_points.delete();
      pending_points <= 0;
    end else begin
      // output valid must always be known once out of reset
      if ($isunknown(point_valid)) begin
        $display("%0t: point_valid expected 0 or 1 actual %b", $time, point_valid);
        mismatch_count++;
      end

      // compare each point transfer against the oldest prediction
      if (point_valid && !point_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: point expected none actual x=%0d y=%0d",
                   $time, point.point_x, point.point_y);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          if (point.point_x !== want.point_x) begin
            $display("%0t: point_x expected %0d actual %0d",
                     $time, want.point_x, point.point_x);
            mismatch_count++;
          end
          if (point.point_y !== want.point_y) begin
            $display("%0t: point_y expected %0d actual %0d",
                     $time, want.point_y, point.point_y);
            mismatch_count++;
          end
        end
      end

      // predict on each sample transfer
      if (sample_valid && !sample_stall) begin
        expected_points.push_back(predict_point(sample));
      end

      // register writes, unknown indexes fall through
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_CALIBRATED: calibrated_q = cfg_data[0];
          CFG_COEF_XX:    gain_xx = int'(cfg_data);
          CFG_COEF_XY:    gain_xy = int'(cfg_data);
          CFG_COEF_XOFF:  bias_x  = int'(cfg_data);
          CFG_COEF_YX:    gain_yx = int'(cfg_data);
          CFG_COEF_YY:    gain_yy = int'(cfg_data);
          CFG_COEF_YOFF:  bias_y  = int'(cfg_data);
          default: ;
        endcase
      end

      pending_points <= expected_points.size();
    end
  end

endmodule

FILE: verif/touch_coordinate_calibration_top_tb.sv
module touch_coordinate_calibration_top_tb;
  import tcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);
  localparam int LONG_HOLD   = 200;
  localparam int DRAIN_SLACK = 8;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 105;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample = '0;
  logic                 point_valid;
  logic                 point_stall = 1'b0;
  point_t               point;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  int mismatch_count;
  int pending_points;

  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;
  bit hold_request    = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  touch_coordinate_calibration_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  tcc_point_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .point_valid    (point_valid),
    .point_stall    (point_stall),
    .point          (point),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_points (pending_points)
  );

  // idle lengths: mostly short, a few long
  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int sender_gap();
    if (sender_steady) return 0;
    if ($urandom_range(0, 99) < 45) return 0;
    return stall_length();
  endfunction

  // raw counts, biased toward the window edges now and then
  function automatic logic [SAMPLE_W-1:0] random_count();
    if ($urandom_range(0, 99) < 85) return SAMPLE_W'($urandom_range(0, 4095));
    case ($urandom_range(0, 7))
      0: return SAMPLE_W'(0);
      1: return SAMPLE_W'(4095);
      2: return SAMPLE_W'(COUNT_LOW - 1);
      3: return SAMPLE_W'(COUNT_LOW);
      4: return SAMPLE_W'(COUNT_LOW + 1);
      5: return SAMPLE_W'(COUNT_HIGH - 1);
      6: return SAMPLE_W'(COUNT_HIGH);
      default: return SAMPLE_W'(COUNT_HIGH + 1);
    endcase
  endfunction

  // mostly plausible calibrations so results land on the panel
  function automatic logic [COEF_W-1:0] random_coef(bit is_offset);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      if (is_offset)
        return COEF_W'(((int'($urandom_range(0, 800)) - 400) <<< FRAC_BITS) +
                       int'($urandom_range(0, 65535)));
      return COEF_W'(int'($urandom_range(0, 20000)) - 10000);
    end
    if (r < 85) return COEF_W'($urandom);
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] sx, input logic [SAMPLE_W-1:0] sy);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    // packed order: sample_x above sample_y
    sample <= {sx, sy};
    do @(posedge clk); while (sample_stall);
  endtask

  // stop offering and let every owed point come out
  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // back to back writes of every register plus the unused index
  task automatic program_regs(input logic [COEF_W-1:0] cal, input logic [COEF_W-1:0] xx,
                              input logic [COEF_W-1:0] xy, input logic [COEF_W-1:0] xoff,
                              input logic [COEF_W-1:0] yx, input logic [COEF_W-1:0] yy,
                              input logic [COEF_W-1:0] yoff);
    cfg_write <= 1'b1;
    cfg_index <= CFG_CALIBRATED; cfg_data <= cal;  @(posedge clk);
    cfg_index <= CFG_COEF_XX;    cfg_data <= xx;   @(posedge clk);
    cfg_index <= CFG_COEF_XY;    cfg_data <= xy;   @(posedge clk);
    cfg_index <= CFG_COEF_XOFF;  cfg_data <= xoff; @(posedge clk);
    cfg_index <= CFG_COEF_YX;    cfg_data <= yx;   @(posedge clk);
    cfg_index <= CFG_COEF_YY;    cfg_data <= yy;   @(posedge clk);
    cfg_index <= CFG_COEF_YOFF;  cfg_data <= yoff; @(posedge clk);
    cfg_index <= CFG_SPARE;      cfg_data <= $urandom; @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // point side back-pressure
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        point_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!receiver_steady && $urandom_range(0, 2) == 0) begin
        point_stall <= 1'b1;
        repeat (stall_length()) @(posedge clk);
      end
      point_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // sample side stimulus and verdict
  initial begin
    logic [COEF_W-1:0] cal_word;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fallback map out of reset: below, at and above the window edges
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd299, 12'd3801);
    send_sample(12'd300, 12'd3800);
    send_sample(12'd301, 12'd3799);
    send_sample(12'd2050, 12'd1234);
    send_sample(12'hAAA, 12'h555);

    // enable written with bit 0 clear keeps the fallback
    wait_idle();
    program_regs(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(12'd1750, 12'd1750);

    // offsets only, fraction floored away
    wait_idle();
    program_regs(32'd1, 32'd0, 32'd0, 32'h0064_0000, 32'd0, 32'd0, 32'h00C7_FFFF);
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095);

    // largest positive coefficients saturate at the panel edge
    wait_idle();
    program_regs(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd0, 12'd0);

    // most negative coefficients clamp to zero
    wait_idle();
    program_regs(32'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd1, 12'd0);

    // plausible calibration: under, inside and over the panel
    wait_idle();
    program_regs(32'd1, 32'd4494, 32'd0, 32'hFFEC_0000, 32'd0, 32'd5992, 32'hFFE5_0000);
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd2000, 12'd2000);

    // mixed signs, and a sum of exactly minus one lsb
    wait_idle();
    program_regs(32'd1, 32'hFFFF_0000, 32'h0001_0000, 32'd0,
                 32'h0000_1000, 32'd0, 32'hFFFF_FFFF);
    send_sample(12'd10, 12'd200);
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd0);

    // random calibrations with random samples
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      cal_word = ($urandom & 32'hFFFF_FFFE) | COEF_W'($urandom_range(0, 3) != 0);
      program_regs(cal_word, random_coef(1'b0), random_coef(1'b0), random_coef(1'b1),
                   random_coef(1'b0), random_coef(1'b0), random_coef(1'b1));
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      // one phase fills the pipe behind a long point stall
      if (phase == 2) begin
        sender_steady   = 1'b1;
        receiver_steady = 1'b0;
        hold_request    = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(random_count(), random_count());
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("touch_coordinate_calibration_top regression: pass");
    end else begin
      $display("touch_coordinate_calibration_top regression: fail");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #10ms;
    $display("touch_coordinate_calibration_top regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
design/tcc_pkg.sv
design/tcc_axis.sv
design/touch_coordinate_calibration_top.sv
verif/tcc_point_checker.sv
verif/touch_coordinate_calibration_top_tb.sv
